// ===== rtl/rbi_pkg.sv =====
// Shared types, constants and helper functions of the rectilinear bilinear interpolator.
`default_nettype none
package rbi_pkg;

   localparam int MAX_X_POINTS_DEF = 16;
   localparam int MAX_Y_POINTS_DEF = 16;

   localparam int VAL_W   = 32;   // Q16.16 value
   localparam int DIFF_W  = 33;   // difference of two values
   localparam int PROD_W  = 64;   // 32x32 product
   localparam int TERM_W  = 96;   // |z| * |a*b|
   localparam int ACC_W   = 100;  // sum of up to four terms, signed
   localparam int DIV_STEPS = ACC_W;
   localparam int CNT_W   = $clog2(DIV_STEPS);

   localparam int POINTS_W  = 5;
   localparam int CSR_IDX_W = 1;
   localparam int INDEX_W   = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_POINTS = 1'b0,
      CSR_Y_POINTS = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_QUERY   = 2'd0,
      MODE_WR_X    = 2'd1,
      MODE_WR_Y    = 2'd2,
      MODE_WR_GRID = 2'd3
   } mode_type;

   // magnitude of a 33-bit signed difference, always fits 32 bits
   function automatic logic [VAL_W-1:0] mag33(input logic [DIFF_W-1:0] v);
      logic [DIFF_W-1:0] n;
      n = v[DIFF_W-1] ? (~v + DIFF_W'(1)) : v;
      return n[VAL_W-1:0];
   endfunction

   function automatic logic [VAL_W-1:0] mag32(input logic [VAL_W-1:0] v);
      return v[VAL_W-1] ? (~v + VAL_W'(1)) : v;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/rbi_if.sv =====
// Valid/ready channel interfaces for request and response items.
`default_nettype none
interface rbi_req_if;
   logic                     valid;
   logic                     ready;
   logic [1:0]               mode;
   logic [7:0]               entry_index;
   logic signed [31:0]       write_value;
   logic signed [31:0]       query_x;
   logic signed [31:0]       query_y;

   modport source (output valid, mode, entry_index, write_value, query_x, query_y,
                   input ready);
   modport sink   (input valid, mode, entry_index, write_value, query_x, query_y,
                   output ready);
endinterface

interface rbi_rsp_if;
   logic                     valid;
   logic                     ready;
   logic signed [31:0]       interpolated;
   logic                     x_clamped;
   logic                     y_clamped;

   modport source (output valid, interpolated, x_clamped, y_clamped, input ready);
   modport sink   (input valid, interpolated, x_clamped, y_clamped, output ready);
endinterface
`default_nettype wire

// ===== rtl/rectilinear_bilinear_interpolator.sv =====
// Bilinear interpolator over a non-uniform grid: stores, search, sequencer and divider.
//
// Usage: request items on req_if either load a store entry (x coordinate, y coordinate
// or grid value, no response) or ask for a query. csr_wen/csr_index/csr_wdata
// set the point counts; write them only while the block is idle.
// A query first reads the axis bounds and clamps the point, then runs a binary search on
// each axis in parallel (about four steps for 16 points), reads the
// cell corners, and accumulates the weighted products in one shared 32x32
// multiplier (four terms for a bilinear cell, two for a linear one).
// A 100-step restoring divider, one quotient bit per cycle, then forms the result.
// req_if.ready is high only while the sequencer idles, so one item is in work at a time.
// The response sits in an output register; if the receiver stalls, the block still takes
// store writes, and a finished query waits in its last step until the register frees.
// Reset (synchronous) sets both point counts to one and clears the sequencer and the
// response valid; store contents are undefined until written.
`default_nettype none
module rectilinear_bilinear_interpolator #(
   parameter int MAX_X_POINTS = rbi_pkg::MAX_X_POINTS_DEF,
   parameter int MAX_Y_POINTS = rbi_pkg::MAX_Y_POINTS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   rbi_req_if.sink                                req_if,
   rbi_rsp_if.source                              rsp_if,
   input  wire logic                              csr_wen,
   input  wire logic [rbi_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [rbi_pkg::POINTS_W-1:0]      csr_wdata
);

   localparam int XAW = (MAX_X_POINTS > 1) ? $clog2(MAX_X_POINTS) : 1;
   localparam int YAW = (MAX_Y_POINTS > 1) ? $clog2(MAX_Y_POINTS) : 1;
   localparam int XCW = $clog2(MAX_X_POINTS + 1);
   localparam int YCW = $clog2(MAX_Y_POINTS + 1);
   localparam int GD  = MAX_X_POINTS * MAX_Y_POINTS;
   localparam int GAW = $clog2(GD);
   localparam int RBW = YAW + XCW;
   localparam int EXW = 17;
   localparam int VW  = rbi_pkg::VAL_W;
   localparam int DW  = rbi_pkg::DIFF_W;
   localparam int PW  = rbi_pkg::PROD_W;
   localparam int TW  = rbi_pkg::TERM_W;
   localparam int AW  = rbi_pkg::ACC_W;
   localparam int CW  = rbi_pkg::CNT_W;

   localparam logic [2:0] SUB_AB  = 3'd0;
   localparam logic [2:0] SUB_LO  = 3'd1;
   localparam logic [2:0] SUB_HI  = 3'd2;
   localparam logic [2:0] SUB_SUM = 3'd3;
   localparam logic [2:0] SUB_ACC = 3'd4;

   typedef enum logic [14:0] {
      ST_IDLE  = 15'b000000000000001,
      ST_LO    = 15'b000000000000010,
      ST_HI    = 15'b000000000000100,
      ST_SADDR = 15'b000000000001000,
      ST_SCMP  = 15'b000000000010000,
      ST_RD1   = 15'b000000000100000,
      ST_RD2   = 15'b000000001000000,
      ST_RD3   = 15'b000000010000000,
      ST_RD4   = 15'b000000100000000,
      ST_DIFF  = 15'b000001000000000,
      ST_MUL   = 15'b000010000000000,
      ST_DEN   = 15'b000100000000000,
      ST_DIVI  = 15'b001000000000000,
      ST_DIV   = 15'b010000000000000,
      ST_FIN   = 15'b100000000000000
   } state_type;

   // configuration
   logic [rbi_pkg::POINTS_W-1:0] x_points_ff, y_points_ff;
   logic [XCW-1:0] nx;
   logic [YCW-1:0] ny;

   // stores
   logic signed [VW-1:0] x_mem [MAX_X_POINTS];
   logic signed [VW-1:0] y_mem [MAX_Y_POINTS];
   logic signed [VW-1:0] g_mem [GD];
   logic signed [VW-1:0] xrd_ff, yrd_ff, grd_ff;
   logic [XAW-1:0] x_raddr;
   logic [YAW-1:0] y_raddr;
   logic [GAW-1:0] g_raddr;
   logic [EXW-1:0] idx_ext;
   logic req_acc, wr_x, wr_y, wr_g;

   // sequencer and datapath
   state_type state_ff, state_in;
   logic signed [VW-1:0] qx_ff, qx_in, qy_ff, qy_in, xlo_ff, xlo_in, ylo_ff, ylo_in;
   logic signed [VW-1:0] xc_ff, xc_in, yc_ff, yc_in, xc1, yc1;
   logic xf_ff, xf_in, yf_ff, yf_in;
   logic [XCW-1:0] xbeg_ff, xbeg_in, xend_ff, xend_in, xmid, i1c;
   logic [YCW-1:0] ybeg_ff, ybeg_in, yend_ff, yend_in, ymid, j1c;
   logic [XCW:0] xsum;
   logic [YCW:0] ysum;
   logic x_act, y_act;
   logic [XAW-1:0] i1_ff, i1_in, i2_ff, i2_in;
   logic [YAW-1:0] j1_ff, j1_in, j2_ff, j2_in;
   logic [RBW-1:0] rb_full;
   logic [GAW-1:0] rb1_ff, rb1_in, rb2_ff, rb2_in;
   logic signed [VW-1:0] x1_ff, x1_in, x2_ff, x2_in, y1_ff, y1_in, y2_ff, y2_in;
   logic signed [VW-1:0] z11_ff, z11_in, z21_ff, z21_in, z12_ff, z12_in, z22_ff, z22_in;
   logic [DW-1:0] dx1_ff, dx1_in, dx2_ff, dx2_in, dy1_ff, dy1_in, dy2_ff, dy2_in;
   logic [DW-1:0] denx_ff, denx_in, deny_ff, deny_in;
   logic xne_ff, xne_in, yne_ff, yne_in, bil;
   logic [1:0] term_ff, term_in;
   logic [2:0] sub_ff, sub_in;
   logic [VW-1:0] tz;
   logic [DW-1:0] ta, tb, d1, d2;
   logic tsub, tneg, last_term;
   logic [VW-1:0] mul_a, mul_b, phi_ff, phi_in;
   logic [PW-1:0] mul_ff, plo_ff, plo_in;
   logic [TW-1:0] tprod_ff, tprod_in;
   logic [AW-1:0] acc_ff, acc_in;
   logic dneg_ff, dneg_in, nneg_ff, nneg_in;
   logic [PW-1:0] den_ff, den_in, rem_ff, rem_in;
   logic [AW-1:0] num_ff, num_in;
   logic [PW:0] rem_sh;
   logic ge;
   logic [VW:0] q_ff, q_in, limit, qv;
   logic sticky_ff, sticky_in, rneg, sat;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [VW-1:0] res;
   logic rsp_valid_ff, rsp_valid_in, can_load;
   logic signed [VW-1:0] rsp_val_ff, rsp_val_in;
   logic rsp_xf_ff, rsp_xf_in, rsp_yf_ff, rsp_yf_in;

   // effective point counts: zero acts as one, large values clip to the maximum
   assign nx = (x_points_ff == '0) ? XCW'(1) :
               ({4'b0, x_points_ff} > 9'(MAX_X_POINTS)) ? XCW'(MAX_X_POINTS) :
               XCW'(x_points_ff);
   assign ny = (y_points_ff == '0) ? YCW'(1) :
               ({4'b0, y_points_ff} > 9'(MAX_Y_POINTS)) ? YCW'(MAX_Y_POINTS) :
               YCW'(y_points_ff);

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_acc = req_if.valid && req_if.ready;
   assign idx_ext = EXW'(req_if.entry_index);
   assign wr_x = req_acc && (req_if.mode == rbi_pkg::MODE_WR_X) &&
                 (idx_ext < EXW'(MAX_X_POINTS));
   assign wr_y = req_acc && (req_if.mode == rbi_pkg::MODE_WR_Y) &&
                 (idx_ext < EXW'(MAX_Y_POINTS));
   assign wr_g = req_acc && (req_if.mode == rbi_pkg::MODE_WR_GRID) &&
                 (idx_ext < EXW'(GD));

   always_ff @(posedge clock) begin
      if (wr_x) x_mem[idx_ext[XAW-1:0]] <= req_if.write_value;
      if (wr_y) y_mem[idx_ext[YAW-1:0]] <= req_if.write_value;
      if (wr_g) g_mem[idx_ext[GAW-1:0]] <= req_if.write_value;
      xrd_ff <= x_mem[x_raddr];
      yrd_ff <= y_mem[y_raddr];
      grd_ff <= g_mem[g_raddr];
   end

   // search helpers
   assign xsum  = {1'b0, xbeg_ff} + {1'b0, xend_ff};
   assign ysum  = {1'b0, ybeg_ff} + {1'b0, yend_ff};
   assign xmid  = xsum[XCW:1];
   assign ymid  = ysum[YCW:1];
   assign x_act = (xend_ff - xbeg_ff) > XCW'(1);
   assign y_act = (yend_ff - ybeg_ff) > YCW'(1);
   // top edge folds into the last cell
   assign i1c = (nx == XCW'(1)) ? '0 :
                (xbeg_ff == nx - XCW'(1)) ? xbeg_ff - XCW'(1) : xbeg_ff;
   assign j1c = (ny == YCW'(1)) ? '0 :
                (ybeg_ff == ny - YCW'(1)) ? ybeg_ff - YCW'(1) : ybeg_ff;
   assign rb_full = RBW'(j1c) * RBW'(nx);

   // clamp: low bound first, then high bound
   assign xc1 = (qx_ff < xlo_ff) ? xlo_ff : qx_ff;
   assign yc1 = (qy_ff < ylo_ff) ? ylo_ff : qy_ff;

   // term operands
   assign bil = xne_ff && yne_ff;
   always_comb begin
      if (bil) begin
         tz   = (term_ff == 2'd0) ? z11_ff : (term_ff == 2'd1) ? z12_ff :
                (term_ff == 2'd2) ? z21_ff : z22_ff;
         ta   = term_ff[1] ? dx1_ff : dx2_ff;
         tb   = term_ff[0] ? dy1_ff : dy2_ff;
         tsub = term_ff[1] ^ term_ff[0];
      end else if (yne_ff) begin
         tz   = term_ff[0] ? z12_ff : z11_ff;
         ta   = term_ff[0] ? dy1_ff : dy2_ff;
         tb   = DW'(1);
         tsub = term_ff[0];
      end else begin
         tz   = term_ff[0] ? z21_ff : z11_ff;
         ta   = term_ff[0] ? dx1_ff : dx2_ff;
         tb   = DW'(1);
         tsub = term_ff[0];
      end
   end
   assign tneg      = tz[VW-1] ^ ta[DW-1] ^ tb[DW-1] ^ tsub;
   assign last_term = bil ? (term_ff == 2'd3) : (term_ff == 2'd1);
   assign d1        = xne_ff ? denx_ff : deny_ff;
   assign d2        = bil ? deny_ff : DW'(1);

   // divider step
   assign rem_sh = {rem_ff, num_ff[AW-1]};
   assign ge     = rem_sh >= {1'b0, den_ff};

   // final saturation
   assign rneg  = nneg_ff ^ dneg_ff;
   assign limit = rneg ? {1'b0, 1'b1, {(VW-1){1'b0}}} : {2'b00, {(VW-1){1'b1}}};
   assign sat   = sticky_ff || (q_ff > limit);
   assign qv    = sat ? limit : q_ff;
   assign res   = (!xne_ff && !yne_ff) ? z11_ff :
                  rneg ? (~qv[VW-1:0] + VW'(1)) : qv[VW-1:0];
   assign can_load = !rsp_valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      mul_ff <= PW'(mul_a) * PW'(mul_b);
   end

   always_comb begin
      state_in = state_ff;
      qx_in = qx_ff;   qy_in = qy_ff;   xlo_in = xlo_ff; ylo_in = ylo_ff;
      xc_in = xc_ff;   yc_in = yc_ff;   xf_in = xf_ff;   yf_in = yf_ff;
      xbeg_in = xbeg_ff; xend_in = xend_ff; ybeg_in = ybeg_ff; yend_in = yend_ff;
      i1_in = i1_ff; i2_in = i2_ff; j1_in = j1_ff; j2_in = j2_ff;
      rb1_in = rb1_ff; rb2_in = rb2_ff;
      x1_in = x1_ff; x2_in = x2_ff; y1_in = y1_ff; y2_in = y2_ff;
      z11_in = z11_ff; z21_in = z21_ff; z12_in = z12_ff; z22_in = z22_ff;
      dx1_in = dx1_ff; dx2_in = dx2_ff; dy1_in = dy1_ff; dy2_in = dy2_ff;
      denx_in = denx_ff; deny_in = deny_ff; xne_in = xne_ff; yne_in = yne_ff;
      term_in = term_ff; sub_in = sub_ff; phi_in = phi_ff; plo_in = plo_ff;
      tprod_in = tprod_ff; acc_in = acc_ff; dneg_in = dneg_ff; nneg_in = nneg_ff;
      den_in = den_ff; num_in = num_ff; rem_in = rem_ff; q_in = q_ff;
      sticky_in = sticky_ff; cnt_in = cnt_ff;
      rsp_val_in = rsp_val_ff; rsp_xf_in = rsp_xf_ff; rsp_yf_in = rsp_yf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      x_raddr = '0; y_raddr = '0; g_raddr = '0;
      mul_a = '0;   mul_b = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_if.mode == rbi_pkg::MODE_QUERY)) begin
               qx_in    = req_if.query_x;
               qy_in    = req_if.query_y;
               state_in = ST_LO;
            end
         end
         ST_LO: begin
            xlo_in   = xrd_ff;
            ylo_in   = yrd_ff;
            x_raddr  = XAW'(nx - XCW'(1));
            y_raddr  = YAW'(ny - YCW'(1));
            state_in = ST_HI;
         end
         ST_HI: begin
            xf_in    = (xlo_ff != xrd_ff) && ((qx_ff < xlo_ff) || (qx_ff > xrd_ff));
            yf_in    = (ylo_ff != yrd_ff) && ((qy_ff < ylo_ff) || (qy_ff > yrd_ff));
            xc_in    = (xc1 > xrd_ff) ? xrd_ff : xc1;
            yc_in    = (yc1 > yrd_ff) ? yrd_ff : yc1;
            xbeg_in  = '0;
            xend_in  = nx;
            ybeg_in  = '0;
            yend_in  = ny;
            state_in = ST_SADDR;
         end
         ST_SADDR: begin
            x_raddr = XAW'(xmid);
            y_raddr = YAW'(ymid);
            if (!x_act && !y_act) begin
               i1_in    = XAW'(i1c);
               i2_in    = (nx == XCW'(1)) ? '0 : XAW'(i1c + XCW'(1));
               j1_in    = YAW'(j1c);
               j2_in    = (ny == YCW'(1)) ? '0 : YAW'(j1c + YCW'(1));
               rb1_in   = GAW'(rb_full);
               state_in = ST_RD1;
            end else begin
               state_in = ST_SCMP;
            end
         end
         ST_SCMP: begin
            if (x_act) begin
               if (xc_ff < xrd_ff) xend_in = xmid;
               else xbeg_in = xmid;
            end
            if (y_act) begin
               if (yc_ff < yrd_ff) yend_in = ymid;
               else ybeg_in = ymid;
            end
            state_in = ST_SADDR;
         end
         ST_RD1: begin
            x_raddr  = i1_ff;
            y_raddr  = j1_ff;
            g_raddr  = GAW'(i1_ff) + rb1_ff;
            rb2_in   = (ny == YCW'(1)) ? rb1_ff : rb1_ff + GAW'(nx);
            state_in = ST_RD2;
         end
         ST_RD2: begin
            x1_in    = xrd_ff;
            y1_in    = yrd_ff;
            z11_in   = grd_ff;
            x_raddr  = i2_ff;
            y_raddr  = j2_ff;
            g_raddr  = GAW'(i2_ff) + rb1_ff;
            state_in = ST_RD3;
         end
         ST_RD3: begin
            x2_in    = xrd_ff;
            y2_in    = yrd_ff;
            z21_in   = grd_ff;
            g_raddr  = GAW'(i1_ff) + rb2_ff;
            state_in = ST_RD4;
         end
         ST_RD4: begin
            z12_in   = grd_ff;
            g_raddr  = GAW'(i2_ff) + rb2_ff;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            z22_in  = grd_ff;
            dx1_in  = {x1_ff[VW-1], x1_ff} - {xc_ff[VW-1], xc_ff};
            dx2_in  = {x2_ff[VW-1], x2_ff} - {xc_ff[VW-1], xc_ff};
            dy1_in  = {y1_ff[VW-1], y1_ff} - {yc_ff[VW-1], yc_ff};
            dy2_in  = {y2_ff[VW-1], y2_ff} - {yc_ff[VW-1], yc_ff};
            denx_in = {x2_ff[VW-1], x2_ff} - {x1_ff[VW-1], x1_ff};
            deny_in = {y2_ff[VW-1], y2_ff} - {y1_ff[VW-1], y1_ff};
            xne_in  = x1_ff != x2_ff;
            yne_in  = y1_ff != y2_ff;
            acc_in  = '0;
            term_in = '0;
            sub_in  = SUB_AB;
            // equal coordinates on both axes: corner value, no arithmetic
            state_in = ((x1_ff != x2_ff) || (y1_ff != y2_ff)) ? ST_MUL : ST_FIN;
         end
         ST_MUL: begin
            case (sub_ff)
               SUB_AB: begin
                  mul_a  = rbi_pkg::mag33(ta);
                  mul_b  = rbi_pkg::mag33(tb);
                  sub_in = SUB_LO;
               end
               SUB_LO: begin
                  mul_a  = rbi_pkg::mag32(tz);
                  mul_b  = mul_ff[VW-1:0];
                  phi_in = mul_ff[PW-1:VW];
                  sub_in = SUB_HI;
               end
               SUB_HI: begin
                  mul_a  = rbi_pkg::mag32(tz);
                  mul_b  = phi_ff;
                  plo_in = mul_ff;
                  sub_in = SUB_SUM;
               end
               SUB_SUM: begin
                  tprod_in = {mul_ff, {VW{1'b0}}} + TW'(plo_ff);
                  sub_in   = SUB_ACC;
               end
               SUB_ACC: begin
                  acc_in  = tneg ? acc_ff - AW'(tprod_ff) : acc_ff + AW'(tprod_ff);
                  sub_in  = SUB_AB;
                  term_in = term_ff + 2'd1;
                  if (last_term) state_in = ST_DEN;
               end
               default: sub_in = SUB_AB;
            endcase
         end
         ST_DEN: begin
            mul_a    = rbi_pkg::mag33(d1);
            mul_b    = rbi_pkg::mag33(d2);
            dneg_in  = d1[DW-1] ^ d2[DW-1];
            state_in = ST_DIVI;
         end
         ST_DIVI: begin
            den_in    = mul_ff;
            nneg_in   = acc_ff[AW-1];
            num_in    = acc_ff[AW-1] ? (~acc_ff + AW'(1)) : acc_ff;
            rem_in    = '0;
            q_in      = '0;
            sticky_in = 1'b0;
            cnt_in    = '0;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            rem_in    = ge ? PW'(rem_sh - {1'b0, den_ff}) : PW'(rem_sh);
            q_in      = {q_ff[VW-1:0], ge};
            sticky_in = sticky_ff | q_ff[VW];
            num_in    = {num_ff[AW-2:0], 1'b0};
            cnt_in    = cnt_ff + CW'(1);
            if (cnt_ff == CW'(rbi_pkg::DIV_STEPS - 1)) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               rsp_val_in   = res;
               rsp_xf_in    = xf_ff;
               rsp_yf_in    = yf_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         x_points_ff  <= rbi_pkg::POINTS_W'(1);
         y_points_ff  <= rbi_pkg::POINTS_W'(1);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen && (csr_index == rbi_pkg::CSR_X_POINTS)) x_points_ff <= csr_wdata;
         if (csr_wen && (csr_index == rbi_pkg::CSR_Y_POINTS)) y_points_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      qx_ff <= qx_in;   qy_ff <= qy_in;   xlo_ff <= xlo_in; ylo_ff <= ylo_in;
      xc_ff <= xc_in;   yc_ff <= yc_in;   xf_ff <= xf_in;   yf_ff <= yf_in;
      xbeg_ff <= xbeg_in; xend_ff <= xend_in; ybeg_ff <= ybeg_in; yend_ff <= yend_in;
      i1_ff <= i1_in; i2_ff <= i2_in; j1_ff <= j1_in; j2_ff <= j2_in;
      rb1_ff <= rb1_in; rb2_ff <= rb2_in;
      x1_ff <= x1_in; x2_ff <= x2_in; y1_ff <= y1_in; y2_ff <= y2_in;
      z11_ff <= z11_in; z21_ff <= z21_in; z12_ff <= z12_in; z22_ff <= z22_in;
      dx1_ff <= dx1_in; dx2_ff <= dx2_in; dy1_ff <= dy1_in; dy2_ff <= dy2_in;
      denx_ff <= denx_in; deny_ff <= deny_in; xne_ff <= xne_in; yne_ff <= yne_in;
      term_ff <= term_in; sub_ff <= sub_in; phi_ff <= phi_in; plo_ff <= plo_in;
      tprod_ff <= tprod_in; acc_ff <= acc_in; dneg_ff <= dneg_in; nneg_ff <= nneg_in;
      den_ff <= den_in; num_ff <= num_in; rem_ff <= rem_in; q_ff <= q_in;
      sticky_ff <= sticky_in; cnt_ff <= cnt_in;
      rsp_val_ff <= rsp_val_in; rsp_xf_ff <= rsp_xf_in; rsp_yf_ff <= rsp_yf_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.interpolated = rsp_val_ff;
   assign rsp_if.x_clamped    = rsp_xf_ff;
   assign rsp_if.y_clamped    = rsp_yf_ff;

   // a response only appears out of the last sequencer step
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("response raised outside final step");

   a_search_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCMP) |-> ((xbeg_ff < xend_ff) && (ybeg_ff < yend_ff)))
      else $error("search interval collapsed");

   a_cell_pair: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD1) |->
         ((i2_ff == i1_ff + XAW'(1)) || ((i1_ff == '0) && (i2_ff == '0))))
      else $error("x cell corners not adjacent");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < den_ff))
      else $error("partial remainder not below divisor");

endmodule
`default_nettype wire

// ===== sim/rectilinear_bilinear_interpolator_tb.sv =====
// Self-checking testbench for the rectilinear bilinear interpolator.
`default_nettype none
module rectilinear_bilinear_interpolator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [31:0] interpolated;
      logic               x_clamped;
      logic               y_clamped;
   } interp_result_type;

   class interp_scoreboard;
      logic [4:0]         x_points_raw, y_points_raw;
      logic signed [31:0] x_coord[16];
      logic signed [31:0] y_coord[16];
      logic signed [31:0] grid_val[256];
      interp_result_type  pending[$];
      int                 fail_count;

      function new();
         x_points_raw = 5'd1;
         y_points_raw = 5'd1;
         fail_count = 0;
         foreach (x_coord[k]) x_coord[k] = '0;
         foreach (y_coord[k]) y_coord[k] = '0;
         foreach (grid_val[k]) grid_val[k] = '0;
      endfunction

      function void set_points(rbi_pkg::csr_index_type idx, logic [4:0] v);
         if (idx == rbi_pkg::CSR_X_POINTS) x_points_raw = v;
         else y_points_raw = v;
      endfunction

      function int used_points(logic [4:0] raw);
         if (raw == 0) return 1;
         return (raw > 16) ? 16 : int'(raw);
      endfunction

      function int find_cell(logic signed [31:0] c[16], int n, longint p);
         int b, e, m;
         b = 0;
         e = n;
         while (e - b > 1) begin
            m = (b + e) / 2;
            if (p < longint'(c[m])) e = m;
            else b = m;
         end
         return b;
      endfunction

      function logic signed [131:0] weight_term(longint z, longint a, longint b);
         logic signed [131:0] zw, aw, bw;
         zw = z;
         aw = a;
         bw = b;
         return zw * aw * bw;
      endfunction

      // truncate toward zero, saturate to 32 bits
      function logic signed [31:0] divide_sat(logic signed [131:0] num, longint d1, longint d2);
         logic signed [131:0] den, q, lim;
         logic                neg;
         den = weight_term(d1, d2, 1);
         neg = (num < 0) ^ (den < 0);
         if (num < 0) num = -num;
         if (den < 0) den = -den;
         q = num / den;
         lim = neg ? 132'sh80000000 : 132'sh7FFFFFFF;
         if (q > lim) q = lim;
         if (neg) q = -q;
         return q[31:0];
      endfunction

      function void note_item(rbi_pkg::mode_type mode, logic [7:0] idx,
                              logic signed [31:0] wv,
                              logic signed [31:0] qx, logic signed [31:0] qy);
         int                  nx, ny, ix, iy, i1, i2, j1, j2;
         longint              x, y, xa, xb, ya, yb, x1, x2, y1, y2, z11, z12, z21, z22;
         logic signed [131:0] acc;
         interp_result_type   r;
         case (mode)
            rbi_pkg::MODE_WR_X: begin
               if (idx < 16) x_coord[idx] = wv;
               return;
            end
            rbi_pkg::MODE_WR_Y: begin
               if (idx < 16) y_coord[idx] = wv;
               return;
            end
            rbi_pkg::MODE_WR_GRID: begin
               grid_val[idx] = wv;
               return;
            end
            default: ;
         endcase
         nx = used_points(x_points_raw);
         ny = used_points(y_points_raw);
         r.x_clamped = 1'b0;
         r.y_clamped = 1'b0;
         if (nx == 1 && ny == 1) begin
            r.interpolated = grid_val[0];
            pending.push_back(r);
            return;
         end
         x = qx;
         y = qy;
         xa = x_coord[0]; xb = x_coord[nx-1];
         ya = y_coord[0]; yb = y_coord[ny-1];
         r.x_clamped = (xa != xb) && (x < xa || x > xb);
         r.y_clamped = (ya != yb) && (y < ya || y > yb);
         if (x < xa) x = xa;
         if (x > xb) x = xb;
         if (y < ya) y = ya;
         if (y > yb) y = yb;
         ix = find_cell(x_coord, nx, x);
         iy = find_cell(y_coord, ny, y);
         // top edge folds into the last cell
         i1 = (nx == 1) ? 0 : ((ix == nx - 1) ? ix - 1 : ix);
         i2 = (nx == 1) ? 0 : i1 + 1;
         j1 = (ny == 1) ? 0 : ((iy == ny - 1) ? iy - 1 : iy);
         j2 = (ny == 1) ? 0 : j1 + 1;
         x1 = x_coord[i1]; x2 = x_coord[i2];
         y1 = y_coord[j1]; y2 = y_coord[j2];
         z11 = grid_val[i1 + j1*nx];
         z21 = grid_val[i2 + j1*nx];
         z12 = grid_val[i1 + j2*nx];
         z22 = grid_val[i2 + j2*nx];
         if (x1 != x2 && y1 != y2) begin
            acc = weight_term(z11, x2 - x, y2 - y) - weight_term(z12, x2 - x, y1 - y)
                - weight_term(z21, x1 - x, y2 - y) + weight_term(z22, x1 - x, y1 - y);
            r.interpolated = divide_sat(acc, x2 - x1, y2 - y1);
         end else if (y1 != y2) begin
            acc = weight_term(z11, y2 - y, 1) - weight_term(z12, y1 - y, 1);
            r.interpolated = divide_sat(acc, y2 - y1, 1);
         end else if (x1 != x2) begin
            acc = weight_term(z11, x2 - x, 1) - weight_term(z21, x1 - x, 1);
            r.interpolated = divide_sat(acc, x2 - x1, 1);
         end else begin
            r.interpolated = z11[31:0];
         end
         pending.push_back(r);
      endfunction

      function void check_result(interp_result_type got);
         interp_result_type exp_r;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result value=%h xc=%b yc=%b", $time,
                     got.interpolated, got.x_clamped, got.y_clamped);
            fail_count++;
            return;
         end
         exp_r = pending.pop_front();
         if (got.interpolated !== exp_r.interpolated) begin
            $display("%0t: interpolated expected %h actual %h", $time,
                     exp_r.interpolated, got.interpolated);
            fail_count++;
         end
         if (got.x_clamped !== exp_r.x_clamped) begin
            $display("%0t: x_clamped expected %b actual %b", $time,
                     exp_r.x_clamped, got.x_clamped);
            fail_count++;
         end
         if (got.y_clamped !== exp_r.y_clamped) begin
            $display("%0t: y_clamped expected %b actual %b", $time,
                     exp_r.y_clamped, got.y_clamped);
            fail_count++;
         end
      endfunction
   endclass

   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 200;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wen = 1'b0;
   rbi_pkg::csr_index_type csr_index = rbi_pkg::CSR_X_POINTS;
   logic [4:0]             csr_wdata = '0;
   bit                     calm = 1'b0;
   int                     idle_count = 0;

   rbi_req_if req_if();
   rbi_rsp_if rsp_if();

   interp_scoreboard sb = new();

   // tb-side copy of the coordinates, used to aim query points
   logic signed [31:0] x_axis[16];
   logic signed [31:0] y_axis[16];

   rectilinear_bilinear_interpolator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if.sink),
      .rsp_if    (rsp_if.source),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // receiver stalls
   int stall_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
         stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready)
         sb.note_item(rbi_pkg::mode_type'(req_if.mode), req_if.entry_index,
                      req_if.write_value, req_if.query_x, req_if.query_y);
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_result('{rsp_if.interpolated, rsp_if.x_clamped, rsp_if.y_clamped});
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || reset)
         idle_count <= 0;
      else
         idle_count <= idle_count + 1;
      if (idle_count >= STALL_LIMIT) begin
         $display("%0t: no progress, giving up", $time);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_item(rbi_pkg::mode_type mode, logic [7:0] idx,
                            logic signed [31:0] wv,
                            logic signed [31:0] qx, logic signed [31:0] qy);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.mode <= mode;
      req_if.entry_index <= idx;
      req_if.write_value <= wv;
      req_if.query_x <= qx;
      req_if.query_y <= qy;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic query(logic signed [31:0] qx, logic signed [31:0] qy);
      send_item(rbi_pkg::MODE_QUERY, 8'($urandom()), $urandom(), qx, qy);
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      // a write gives no result; let any item still in work finish
      repeat (150) @(posedge clock);
   endtask

   task automatic set_points(rbi_pkg::csr_index_type idx, logic [4:0] v);
      wait_idle();
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen <= 1'b0;
      sb.set_points(idx, v);
   endtask

   // ascending axis (shape 3 aside); shape 0 narrow, 1 full range, 2 with repeats, 3 unordered
   task automatic load_axis(bit is_y, int shape);
      longint v, step;
      v = (shape == 1) ? -64'sd2147483648 :
          $signed(longint'($urandom_range(0, 1 << 24))) - (1 << 23);
      for (int k = 0; k < 16; k++) begin
         if (shape == 3) v = $signed($urandom());
         if (is_y) begin
            y_axis[k] = 32'(v);
            send_item(rbi_pkg::MODE_WR_Y, 8'(k), 32'(v), '0, '0);
         end else begin
            x_axis[k] = 32'(v);
            send_item(rbi_pkg::MODE_WR_X, 8'(k), 32'(v), '0, '0);
         end
         if (shape == 1) step = 64'sd268435455 - $urandom_range(0, 1000);
         else if (shape == 2 && $urandom_range(0, 2) == 0) step = 0;
         else step = $urandom_range(1, 1 << 20);
         v = v + step;
      end
   endtask

   function automatic logic signed [31:0] aim(logic signed [31:0] axis[16], int n);
      int     r, k;
      longint lo, hi;
      r = $urandom_range(0, 99);
      k = $urandom_range(0, n - 1);
      if (r < 10) return $urandom();
      if (r < 30) return axis[k];
      lo = axis[0];
      hi = axis[n-1];
      if (hi < lo) hi = lo;
      lo = lo - 100;
      hi = hi + 100;
      if (lo < -64'sd2147483648) lo = -64'sd2147483648;
      if (hi > 64'sd2147483647) hi = 64'sd2147483647;
      return 32'(lo + longint'({$urandom(), $urandom()} % (hi - lo + 1)));
   endfunction

   initial begin
      logic [4:0] xs_list[6], ys_list[6];
      int         nxp, nyp;
      req_if.valid = 1'b0;
      req_if.mode = rbi_pkg::MODE_QUERY;
      req_if.entry_index = '0;
      req_if.write_value = '0;
      req_if.query_x = '0;
      req_if.query_y = '0;
      xs_list = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd5, 5'd1};
      ys_list = '{5'd2, 5'd17, 5'd16, 5'd1, 5'd0, 5'd9};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill every store entry before anything reads it
      load_axis(1'b0, 0);
      load_axis(1'b1, 0);
      for (int k = 0; k < 256; k++)
         send_item(rbi_pkg::MODE_WR_GRID, 8'(k), $urandom(), '0, '0);

      // single-point grid, then extremes of the query fields
      query(32'sh7FFFFFFF, 32'sh80000000);
      send_item(rbi_pkg::MODE_WR_X, 8'd200, $urandom(), '0, '0);
      send_item(rbi_pkg::MODE_WR_Y, 8'd255, $urandom(), '0, '0);
      set_points(rbi_pkg::CSR_X_POINTS, 5'd16);
      query(32'sh80000000, y_axis[0]);
      set_points(rbi_pkg::CSR_Y_POINTS, 5'd16);
      query(32'sh80000000, 32'sh80000000);
      query(32'sh7FFFFFFF, 32'sh7FFFFFFF);
      query(x_axis[15], y_axis[15]);
      query(x_axis[0], y_axis[15]);
      query(x_axis[7], y_axis[3]);
      send_item(rbi_pkg::MODE_WR_GRID, 8'd17, 32'sh7FFFFFFF, '0, '0);
      send_item(rbi_pkg::MODE_WR_GRID, 8'd18, 32'sh80000000, '0, '0);
      query(x_axis[1] + 1, y_axis[1] + 1);
      set_points(rbi_pkg::CSR_X_POINTS, 5'd1);
      query(32'sh7FFFFFFF, y_axis[4] + 5);
      set_points(rbi_pkg::CSR_X_POINTS, 5'd16);
      set_points(rbi_pkg::CSR_Y_POINTS, 5'd1);
      query(x_axis[4] + 5, 32'sh80000000);
      // equal cell coordinates on both axes
      set_points(rbi_pkg::CSR_Y_POINTS, 5'd2);
      wait_idle();
      send_item(rbi_pkg::MODE_WR_X, 8'd1, x_axis[0], '0, '0);
      send_item(rbi_pkg::MODE_WR_Y, 8'd1, y_axis[0], '0, '0);
      set_points(rbi_pkg::CSR_X_POINTS, 5'd2);
      query(x_axis[0], y_axis[0]);
      query(32'sh7FFFFFFF, 32'sh80000000);

      for (int ph = 0; ph < 8; ph++) begin
         calm = (ph % 3 == 2);
         load_axis(1'b0, $urandom_range(0, 9) < 7 ? $urandom_range(0, 2) : 3);
         load_axis(1'b1, $urandom_range(0, 9) < 7 ? $urandom_range(0, 2) : 3);
         set_points(rbi_pkg::CSR_X_POINTS, xs_list[ph % 6]);
         set_points(rbi_pkg::CSR_Y_POINTS, ys_list[(ph + 1) % 6]);
         nxp = sb.used_points(sb.x_points_raw);
         nyp = sb.used_points(sb.y_points_raw);
         for (int k = 0; k < 105; k++) begin
            if ($urandom_range(0, 5) == 0)
               send_item(rbi_pkg::MODE_WR_GRID, 8'($urandom()), $urandom(), '0, '0);
            else
               query(aim(x_axis, nxp), aim(y_axis, nyp));
         end
      end

      calm = 1'b0;
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.fail_count == 0 && sb.pending.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/rbi_pkg.sv
rtl/rbi_if.sv
rtl/rectilinear_bilinear_interpolator.sv
sim/rectilinear_bilinear_interpolator_tb.sv
